>>> src/fold_vector_first_brillouin_zone_top_macros.svh
// Assertion macros shared by the checker.
// Each macro expects clk_i and rst_ni in scope.
`ifndef FOLD_VECTOR_FIRST_BRILLOUIN_ZONE_TOP_MACROS_SVH
`define FOLD_VECTOR_FIRST_BRILLOUIN_ZONE_TOP_MACROS_SVH

// Same-cycle implication
`define BZF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BZF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bzf_pkg.sv
package bzf_pkg;

  // Packed width of one reciprocal vector component in the registers
  localparam int unsigned PACK_WIDTH = 20;
  localparam int unsigned REC_WIDTH  = 3 * PACK_WIDTH;
  localparam int unsigned CFG_IDX_W  = 2;

  // Configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_NUM_VECTORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_A     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_B     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_C     = 2'd3;

  // Component phase codes within one candidate
  localparam logic [1:0] COMP_X    = 2'd0;
  localparam logic [1:0] COMP_Y    = 2'd1;
  localparam logic [1:0] COMP_Z    = 2'd2;
  localparam logic [1:0] COMP_LAST = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAND,
    ST_PASS_END,
    ST_DONE
  } bzf_state_e;

  // Sequencer to datapath control
  typedef struct packed {
    logic       active;
    logic       is_k;
    logic       sub;
    logic [1:0] vidx;
    logic [1:0] comp;
    logic       adopt;
    logic       finish;
    logic       not_conv;
  } bzf_ctrl_t;

endpackage

>>> src/bzf_sqacc.sv
module bzf_sqacc #(
  parameter int unsigned COMP_WIDTH = 20
) (
  input  logic                                   clk_i,
  input  bzf_pkg::bzf_ctrl_t                     ctrl_i,
  input  logic signed [COMP_WIDTH-1:0]           k_comp_i,
  input  logic signed [bzf_pkg::PACK_WIDTH-1:0]  g_comp_i,
  output logic signed [COMP_WIDTH-1:0]           cand_comp_o,
  output logic                                   better_o
);
  import bzf_pkg::*;

  localparam int unsigned EW  = ((COMP_WIDTH > PACK_WIDTH) ? COMP_WIDTH : PACK_WIDTH) + 1;
  localparam int unsigned PRW = 2 * COMP_WIDTH;
  localparam int unsigned AW  = PRW + 2;

  logic signed [EW-1:0]         k_ext;
  logic signed [EW-1:0]         g_ext;
  logic signed [EW-1:0]         sum;
  logic                         fits;
  logic signed [COMP_WIDTH-1:0] cand;
  logic [COMP_WIDTH-1:0]        mag;
  logic [PRW-1:0]               prod_d;
  logic [PRW-1:0]               prod_q;
  logic [AW-1:0]                acc_d;
  logic [AW-1:0]                acc_q;
  logic [AW-1:0]                norm;
  logic [AW-1:0]                best_n_q;

  // Candidate component: k, k+g or k-g, saturated to the component range
  always_comb begin
    k_ext = {{(EW-COMP_WIDTH){k_comp_i[COMP_WIDTH-1]}}, k_comp_i};
    g_ext = {{(EW-PACK_WIDTH){g_comp_i[PACK_WIDTH-1]}}, g_comp_i};
    sum   = ctrl_i.sub ? (k_ext - g_ext) : (k_ext + g_ext);
    fits  = (&sum[EW-1:COMP_WIDTH-1]) | ~(|sum[EW-1:COMP_WIDTH-1]);
    if (ctrl_i.is_k) begin
      cand = k_comp_i;
    end else if (fits) begin
      cand = sum[COMP_WIDTH-1:0];
    end else if (sum[EW-1]) begin
      cand = {1'b1, {(COMP_WIDTH-1){1'b0}}};
    end else begin
      cand = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    end
  end

  assign cand_comp_o = cand;

  // Shared squaring multiplier
  assign mag    = cand[COMP_WIDTH-1] ? (~cand + 1'b1) : cand;
  assign prod_d = PRW'(mag) * PRW'(mag);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Accumulate one product per cycle, compare on the last phase
  assign norm     = acc_q + AW'(prod_q);
  assign better_o = ctrl_i.is_k | (norm < best_n_q);

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.comp)
      COMP_Y:  acc_d = AW'(prod_q);
      COMP_Z:  acc_d = norm;
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.active) begin
      acc_q <= acc_d;
      if (ctrl_i.comp == COMP_LAST && better_o) begin
        best_n_q <= norm;
      end
    end
  end

endmodule

>>> src/bzf_seq.sv
module bzf_seq #(
  parameter int unsigned MAX_PASSES  = 64,
  parameter int unsigned MAX_VECTORS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         num_vectors_i,
  input  logic               moved_i,
  input  logic               out_free_i,
  output logic               busy_o,
  output bzf_pkg::bzf_ctrl_t ctrl_o
);
  import bzf_pkg::*;

  localparam int unsigned   PW        = $clog2(MAX_PASSES + 1);
  localparam logic [PW-1:0] LAST_PASS = PW'(MAX_PASSES - 1);
  localparam logic [1:0]    NV_MAX    = 2'(MAX_VECTORS);

  bzf_state_e    state_q, state_d;
  logic [1:0]    comp_q;
  logic [1:0]    vidx_q;
  logic          is_k_q;
  logic          sub_q;
  logic          nc_q;
  logic [PW-1:0] pass_q;
  logic [1:0]    nv_eff;
  logic [1:0]    nv_last;
  logic          cand_end;
  logic          last_cand;
  logic          pass_limit;
  logic          restart;

  // Effective vector count and candidate bookkeeping
  assign nv_eff     = (num_vectors_i > NV_MAX) ? NV_MAX : num_vectors_i;
  assign nv_last    = nv_eff - 2'd1;
  assign cand_end   = (state_q == ST_CAND) && (comp_q == COMP_LAST);
  assign last_cand  = is_k_q ? (nv_eff == 2'd0) : (sub_q && (vidx_q == nv_last));
  assign pass_limit = (pass_q == LAST_PASS);
  assign restart    = start_i || ((state_q == ST_PASS_END) && moved_i && !pass_limit);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start_i) state_d = ST_CAND;
      ST_CAND:     if (cand_end && last_cand) state_d = ST_PASS_END;
      ST_PASS_END: begin
        if (!moved_i || pass_limit) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_CAND;
        end
      end
      ST_DONE:     if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Candidate, component and pass counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q <= COMP_X;
      vidx_q <= 2'd0;
      is_k_q <= 1'b1;
      sub_q  <= 1'b0;
      pass_q <= '0;
      nc_q   <= 1'b0;
    end else begin
      if (restart) begin
        comp_q <= COMP_X;
        vidx_q <= 2'd0;
        is_k_q <= 1'b1;
        sub_q  <= 1'b0;
      end else if (state_q == ST_CAND) begin
        comp_q <= comp_q + 2'd1;
        if (comp_q == COMP_LAST) begin
          if (is_k_q) begin
            is_k_q <= 1'b0;
            sub_q  <= 1'b0;
            vidx_q <= 2'd0;
          end else if (vidx_q == nv_last) begin
            sub_q  <= 1'b1;
            vidx_q <= 2'd0;
          end else begin
            vidx_q <= vidx_q + 2'd1;
          end
        end
      end
      if (start_i) begin
        pass_q <= '0;
      end else if ((state_q == ST_PASS_END) && moved_i) begin
        pass_q <= pass_q + 1'b1;
      end
      if (state_q == ST_PASS_END) begin
        nc_q <= moved_i;
      end
    end
  end

  // Control outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.active   = (state_q == ST_CAND);
    ctrl_o.is_k     = is_k_q;
    ctrl_o.sub      = sub_q;
    ctrl_o.vidx     = vidx_q;
    ctrl_o.comp     = comp_q;
    ctrl_o.adopt    = (state_q == ST_PASS_END) && moved_i;
    ctrl_o.finish   = (state_q == ST_DONE) && out_free_i;
    ctrl_o.not_conv = nc_q;
    busy_o          = (state_q != ST_IDLE);
  end

endmodule

>>> src/fold_vector_first_brillouin_zone_top.sv
// Folds a 3-D wave vector (signed fixed point, COMP_WIDTH bits a component)
// into the first Brillouin zone of up to three reciprocal vectors.
// Input channel: in_valid_i / in_stall_o with vec_in_{x,y,z}_i. A request is
// taken when valid is high and stall low; stall stays high while one vector
// is being folded.
// Output channel: out_valid_o / out_stall_i with vec_out_{x,y,z}_o and
// not_converged_o, held in an output register. A new request is taken while
// a finished result still waits there.
// Each pass scores 2*nv+1 candidates on one squaring multiplier, each as
// three products, then an add and compare, and then adopts the shortest.
// A vector is folded in between 1 and MAX_PASSES passes. The next request
// can be taken in the same cycle the result appears; a new request is only
// taken once the last one is finished.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is to be written by the
// user only while idle; the block itself does not enforce this.
// Reset clears the sequencer and output valid, sets num_vectors to 3 and the
// reciprocal vectors to zero. A stalled receiver holds the result; the block
// finishes the item in flight and waits with it before going idle.
module fold_vector_first_brillouin_zone_top #(
  parameter int unsigned MAX_PASSES  = 64,
  parameter int unsigned COMP_WIDTH  = 20,
  parameter int unsigned MAX_VECTORS = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bzf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bzf_pkg::REC_WIDTH-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [COMP_WIDTH-1:0]         vec_in_x_i,
  input  logic signed [COMP_WIDTH-1:0]         vec_in_y_i,
  input  logic signed [COMP_WIDTH-1:0]         vec_in_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [COMP_WIDTH-1:0]         vec_out_x_o,
  output logic signed [COMP_WIDTH-1:0]         vec_out_y_o,
  output logic signed [COMP_WIDTH-1:0]         vec_out_z_o,
  output logic                                 not_converged_o
);
  import bzf_pkg::*;

  logic [1:0]                   num_vectors_q;
  logic [REC_WIDTH-1:0]         recip_q [3];
  logic signed [COMP_WIDTH-1:0] k_q     [3];
  logic signed [COMP_WIDTH-1:0] cand_q  [3];
  logic signed [COMP_WIDTH-1:0] best_q  [3];
  logic                         moved_q;
  logic                         out_valid_q;
  logic                         nc_out_q;
  logic signed [COMP_WIDTH-1:0] out_q   [3];

  bzf_ctrl_t                    ctrl;
  logic                         busy;
  logic                         in_fire;
  logic                         out_free;
  logic signed [COMP_WIDTH-1:0] k_comp;
  logic [REC_WIDTH-1:0]         g_vec;
  logic signed [PACK_WIDTH-1:0] g_comp;
  logic signed [COMP_WIDTH-1:0] cand_comp;
  logic                         better;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vectors_q <= 2'd3;
      recip_q[0]    <= '0;
      recip_q[1]    <= '0;
      recip_q[2]    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_VECTORS: num_vectors_q <= cfg_data_i[1:0];
        REG_RECIP_A:     recip_q[0]    <= cfg_data_i;
        REG_RECIP_B:     recip_q[1]    <= cfg_data_i;
        REG_RECIP_C:     recip_q[2]    <= cfg_data_i;
        default:         num_vectors_q <= num_vectors_q;
      endcase
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    case (ctrl.comp)
      COMP_Y:  k_comp = k_q[1];
      COMP_Z:  k_comp = k_q[2];
      default: k_comp = k_q[0];
    endcase
    case (ctrl.vidx)
      2'd1:    g_vec = recip_q[1];
      2'd2:    g_vec = recip_q[2];
      default: g_vec = recip_q[0];
    endcase
    case (ctrl.comp)
      COMP_Y:  g_comp = g_vec[PACK_WIDTH +: PACK_WIDTH];
      COMP_Z:  g_comp = g_vec[2*PACK_WIDTH +: PACK_WIDTH];
      default: g_comp = g_vec[0 +: PACK_WIDTH];
    endcase
  end

  bzf_seq #(
    .MAX_PASSES  (MAX_PASSES),
    .MAX_VECTORS (MAX_VECTORS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_fire),
    .num_vectors_i (num_vectors_q),
    .moved_i       (moved_q),
    .out_free_i    (out_free),
    .busy_o        (busy),
    .ctrl_o        (ctrl)
  );

  bzf_sqacc #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_sqacc (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .k_comp_i    (k_comp),
    .g_comp_i    (g_comp),
    .cand_comp_o (cand_comp),
    .better_o    (better)
  );

  // Working vector, candidate and best-so-far
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      k_q[0] <= vec_in_x_i;
      k_q[1] <= vec_in_y_i;
      k_q[2] <= vec_in_z_i;
    end else if (ctrl.adopt) begin
      k_q <= best_q;
    end
    if (ctrl.active) begin
      case (ctrl.comp)
        COMP_X:  cand_q[0] <= cand_comp;
        COMP_Y:  cand_q[1] <= cand_comp;
        COMP_Z:  cand_q[2] <= cand_comp;
        default: if (better) best_q <= cand_q;
      endcase
    end
  end

  // Pass moved flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moved_q <= 1'b0;
    end else if (ctrl.active && (ctrl.comp == COMP_LAST)) begin
      moved_q <= ctrl.is_k ? 1'b0 : (moved_q | better);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) begin
      out_q    <= k_q;
      nc_out_q <= ctrl.not_conv;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vec_out_x_o     = out_q[0];
  assign vec_out_y_o     = out_q[1];
  assign vec_out_z_o     = out_q[2];
  assign not_converged_o = nc_out_q;

endmodule

>>> src/bzf_chk.sv
`include "fold_vector_first_brillouin_zone_top_macros.svh"

module bzf_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic not_converged_o
);

  // One vector in flight: a taken request blocks the next one
  `BZF_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

  // No result can appear the cycle after a request
  `BZF_ASSERT_NEXT(a_min_latency, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o, "result too early")

  // A new result only follows a busy cycle
  `BZF_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(in_stall_o), "result without work")

  // A stalled result stays valid and keeps its not_converged flag
  `BZF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(not_converged_o), "stalled result changed")

endmodule

bind fold_vector_first_brillouin_zone_top bzf_chk u_bzf_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .not_converged_o (not_converged_o)
);

>>> test/tb.sv
module tb;
  import bzf_pkg::*;

  localparam int COMP_W      = 20;
  localparam int MAX_PASSES  = 64;
  localparam int MAX_VECS    = 3;
  // cycles a pass takes with all three vectors active
  localparam int PASS_CYCLES = 8 * MAX_VECS + 5;
  localparam int END_WAIT    = 2 + MAX_PASSES * PASS_CYCLES;
  localparam int QUIET_LIMIT = 20000;
  localparam int LONG_HOLD   = 300;

  localparam longint CMAX = (64'sd1 <<< (COMP_W - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  // Q4.16 constants
  localparam int ONE      = 65536;
  localparam int HALF     = 32768;
  localparam int HEX_SIN  = 56756;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [REC_WIDTH-1:0] rec_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  nc;
  } folded_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  rec_t                 cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  comp_t                vec_in_x_i;
  comp_t                vec_in_y_i;
  comp_t                vec_in_z_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  comp_t                vec_out_x_o;
  comp_t                vec_out_y_o;
  comp_t                vec_out_z_o;
  logic                 not_converged_o;

  // mirror of the lattice registers
  logic [1:0] lat_count = 2'd3;
  rec_t       lat_vecs [3] = '{default: '0};

  folded_t folds_due [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      rx_hold_cycles = 0;
  bit      idle_on = 1'b1;

  fold_vector_first_brillouin_zone_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .vec_in_x_i      (vec_in_x_i),
    .vec_in_y_i      (vec_in_y_i),
    .vec_in_z_i      (vec_in_z_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vec_out_x_o     (vec_out_x_o),
    .vec_out_y_o     (vec_out_y_o),
    .vec_out_z_o     (vec_out_z_o),
    .not_converged_o (not_converged_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint clamp_comp(input longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint sq_len(input longint a, input longint b, input longint c);
    return a * a + b * b + c * c;
  endfunction

  // Fold k into the first zone of the mirrored lattice
  function automatic folded_t fold_into_zone(input comp_t kx, input comp_t ky,
                                             input comp_t kz);
    longint  k [3];
    longint  g [3][3];
    longint  best [3];
    longint  cand [3];
    longint  best_len;
    longint  len;
    int      nv;
    comp_t   part;
    bit      moved;
    bit      settled;
    folded_t r;
    nv = (lat_count > MAX_VECS) ? MAX_VECS : lat_count;
    k[0] = kx;
    k[1] = ky;
    k[2] = kz;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        part = lat_vecs[i][PACK_WIDTH*j +: PACK_WIDTH];
        g[i][j] = part;
      end
    end
    settled = 1'b0;
    for (int p = 0; p < MAX_PASSES; p++) begin
      if (!settled) begin
        moved = 1'b0;
        best = k;
        best_len = sq_len(k[0], k[1], k[2]);
        // candidate order: k, all k+G, then all k-G; strict compare keeps the earlier
        for (int s = 0; s < 2; s++) begin
          for (int i = 0; i < nv; i++) begin
            for (int j = 0; j < 3; j++)
              cand[j] = clamp_comp(s != 0 ? k[j] - g[i][j] : k[j] + g[i][j]);
            len = sq_len(cand[0], cand[1], cand[2]);
            if (len < best_len) begin
              best_len = len;
              best = cand;
              moved = 1'b1;
            end
          end
        end
        if (moved) k = best;
        else settled = 1'b1;
      end
    end
    r.x = k[0][COMP_W-1:0];
    r.y = k[1][COMP_W-1:0];
    r.z = k[2][COMP_W-1:0];
    r.nc = !settled;
    return r;
  endfunction

  function automatic rec_t pack_recip(input comp_t x, input comp_t y, input comp_t z);
    return {z, y, x};
  endfunction

  // uniform over a signed range of w bits
  function automatic comp_t rand_comp(input int unsigned w);
    int half;
    if (w >= COMP_W) return comp_t'($urandom);
    half = 1 << (w - 1);
    return comp_t'($urandom_range(0, 2 * half - 1) - half);
  endfunction

  function automatic rec_t rand_recip(input int unsigned w);
    return pack_recip(rand_comp(w), rand_comp(w), rand_comp(w));
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: one request, optional gap before it
  task automatic send_wave_vector(input comp_t x, input comp_t y, input comp_t z);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vec_in_x_i <= x;
    vec_in_y_i <= y;
    vec_in_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    folds_due.push_back(fold_into_zone(x, y, z));
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (folds_due.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers once the block has drained
  task automatic set_config(input logic [1:0] nv, input rec_t a, input rec_t b,
                            input rec_t c);
    rec_t                 vals [4];
    logic [CFG_IDX_W-1:0] idx [4];
    wait_results_done();
    idx = '{REG_NUM_VECTORS, REG_RECIP_A, REG_RECIP_B, REG_RECIP_C};
    // upper bits of the count register are junk
    vals[0] = rec_t'({$urandom, $urandom});
    vals[0][1:0] = nv;
    vals[1] = a;
    vals[2] = b;
    vals[3] = c;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      if (idx[i] == REG_NUM_VECTORS) lat_count = vals[i][1:0];
      else lat_vecs[idx[i] - REG_RECIP_A] = vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_config(input int unsigned g_width);
    logic [1:0] nv;
    nv = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    set_config(nv, rand_recip(g_width), rand_recip(g_width), rand_recip(g_width));
  endtask

  task automatic send_random_vectors(input int n);
    int unsigned kw;
    repeat (n) begin
      kw = $urandom_range(0, 1) ? COMP_W : $urandom_range(4, COMP_W);
      send_wave_vector(rand_comp(kw), rand_comp(kw), rand_comp(kw));
    end
  endtask

  // Reset lattice is all zero: nothing moves
  task automatic test_reset_state();
    send_wave_vector(comp_t'(CMAX), comp_t'(CMIN), comp_t'(20'h55555));
    send_wave_vector(comp_t'(CMIN), comp_t'(CMAX), comp_t'(20'hAAAAA));
  endtask

  // Simple cubic lattice, ties on the zone faces
  task automatic test_cubic_lattice();
    set_config(2'd3, pack_recip(ONE, 0, 0), pack_recip(0, ONE, 0), pack_recip(0, 0, ONE));
    send_wave_vector(HALF, 0, 0);
    send_wave_vector(-HALF, HALF, -HALF);
    send_wave_vector(ONE + HALF, -(2 * ONE + ONE / 4), 3 * ONE + 3 * ONE / 4);
    send_wave_vector(comp_t'(CMAX), comp_t'(CMAX), comp_t'(CMAX));
    send_wave_vector(comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN));
    send_wave_vector(0, 0, 0);
  endtask

  // No vectors, then one, then a hexagonal pair
  task automatic test_vector_count();
    set_config(2'd0, pack_recip(ONE, ONE, 0), pack_recip(0, ONE, ONE), pack_recip(ONE, 0, ONE));
    send_wave_vector(3 * ONE, -3 * ONE, ONE);
    set_config(2'd1, pack_recip(ONE, ONE, 0), pack_recip(0, ONE, ONE), pack_recip(ONE, 0, ONE));
    send_wave_vector(3 * ONE, 3 * ONE, 0);
    send_wave_vector(comp_t'(CMIN), 0, comp_t'(CMAX));
    set_config(2'd2, pack_recip(ONE, 0, 0), pack_recip(HALF, HEX_SIN, 0), '0);
    send_wave_vector(2 * ONE, 2 * ONE, ONE);
    send_wave_vector(-5 * ONE, 3 * ONE, 0);
  endtask

  // Candidates that leave the component range clip
  task automatic test_saturation();
    set_config(2'd2, pack_recip(comp_t'(CMAX), comp_t'(CMAX), comp_t'(CMAX)),
               pack_recip(comp_t'(CMIN), comp_t'(CMIN), comp_t'(CMIN)), '0);
    send_wave_vector(comp_t'(CMAX), comp_t'(CMIN), 0);
    send_wave_vector(comp_t'(CMIN), comp_t'(CMAX), 1);
    send_wave_vector(comp_t'(CMAX), comp_t'(CMAX), comp_t'(CMAX));
  endtask

  // Short vector, long k: pass limit just hit and just missed
  task automatic test_pass_limit();
    set_config(2'd1, pack_recip(64, 0, 0), '0, '0);
    send_wave_vector(4100, 0, 0);
    send_wave_vector(64 * 63 + 10, 0, 0);
    send_wave_vector(-300000, 7, -7);
  endtask

  task automatic test_random_folding();
    for (int p = 0; p < 11; p++) begin
      random_config((p % 4 == 3) ? COMP_W : $urandom_range(15, COMP_W - 1));
      send_random_vectors(150);
    end
  endtask

  // Receiver holds off while requests keep coming
  task automatic test_long_stall();
    random_config(17);
    send_random_vectors(2);
    rx_hold_cycles = LONG_HOLD;
    send_random_vectors(38);
  endtask

  task automatic test_drain_pause();
    random_config(16);
    send_random_vectors(20);
    wait_results_done();
    send_random_vectors(20);
  endtask

  // Tiny lattice: mostly runs into the pass limit
  task automatic test_tiny_lattice();
    random_config(9);
    send_random_vectors(12);
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    random_config(17);
    send_random_vectors(140);
  endtask

  // Receiver: random stall bursts, or a long hold on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result check against the oldest pending fold
  always @(posedge clk_i) begin : check_folded
    folded_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (folds_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d nc=%0b",
                 $time, vec_out_x_o, vec_out_y_o, vec_out_z_o, not_converged_o);
        mismatches++;
      end else begin
        want = folds_due.pop_front();
        check_field("vec_out_x", want.x, vec_out_x_o);
        check_field("vec_out_y", want.y, vec_out_y_o);
        check_field("vec_out_z", want.z, vec_out_z_o);
        check_field("not_converged", want.nc, not_converged_o);
      end
    end
  end

  // Watchdog on cycles with no progress
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_NUM_VECTORS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    vec_in_x_i = '0;
    vec_in_y_i = '0;
    vec_in_z_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_cubic_lattice();
    test_vector_count();
    test_saturation();
    test_pass_limit();
    test_random_folding();
    test_long_stall();
    test_drain_pause();
    test_tiny_lattice();
    test_no_idle();
    wait_results_done();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && folds_due.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
